### rtl/access_fact_table_builder_top_macros.svh
// assertion macros for the access fact table builder checker
`ifndef ACCESS_FACT_TABLE_BUILDER_TOP_MACROS_SVH
`define ACCESS_FACT_TABLE_BUILDER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define AFT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define AFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/aft_pkg.sv
// shared types, sizes and codes of the access fact table builder
package aft_pkg;

  // store geometry
  localparam int unsigned MAX_ALIASES = 256;
  localparam int unsigned NUM_BND     = 64;
  localparam int unsigned ALIAS_W     = $clog2(MAX_ALIASES);
  localparam int unsigned BND_W       = $clog2(NUM_BND);
  localparam int unsigned CELL_W      = ALIAS_W + BND_W;
  localparam int unsigned NUM_CELLS   = MAX_ALIASES * NUM_BND;

  // field widths
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned TASK_W      = 6;
  localparam int unsigned POS_W       = 15;
  localparam int unsigned ACOUNT_W    = 9;
  localparam int unsigned CFG_DATA_W  = 9;
  localparam int unsigned CFG_IDX_W   = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ   = 3'd0,
    CMD_MUTATE = 3'd1,
    CMD_OUTPUT = 3'd2,
    CMD_LIST   = 3'd3,
    CMD_QUERY  = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK    = 3'd0,
    KIND_ENTRY  = 3'd1,
    KIND_ANSWER = 3'd2,
    KIND_NONE   = 3'd3,
    KIND_ERROR  = 3'd4
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALIAS_COUNT = 1'b0,
    CFG_TASK_COUNT  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LIST
  } state_e;

  // one row per alias: write marks and per-cell valid bits
  typedef struct packed {
    logic [NUM_BND-1:0] wmap;
    logic [NUM_BND-1:0] cvalid;
  } meta_t;

  // sequencer to store requests
  typedef struct packed {
    logic               rd_en;
    logic [ALIAS_W-1:0] rd_alias;
    logic [BND_W-1:0]   rd_bnd;
    logic               store_we;
    logic               meta_we;
    logic [ALIAS_W-1:0] wr_alias;
    logic [BND_W-1:0]   wr_bnd;
    logic [TASK_W-1:0]  store_wdata;
    meta_t              meta_wdata;
    logic               clear_all;
  } mem_req_t;

  // one result beat
  typedef struct packed {
    kind_e              kind;
    logic [ALIAS_W-1:0] alias_out;
    logic [BND_W-1:0]   bnd;
    logic [POS_W-1:0]   pos;
    logic [TASK_W-1:0]  early;
    logic               found;
    logic               last;
  } res_t;

endpackage

### rtl/aft_store.sv
// earliest-task memory, per-alias mark/valid rows and row valid flops
module aft_store
  import aft_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output meta_t    meta_rdata_o,
  output logic [TASK_W-1:0] store_rdata_o
);

  logic [TASK_W-1:0]      store_mem [NUM_CELLS];
  meta_t                  meta_mem  [MAX_ALIASES];
  logic [MAX_ALIASES-1:0] rowv_q;
  logic                   rd_rowv_q;
  meta_t                  meta_q;
  logic [TASK_W-1:0]      store_q;

  // earliest-task memory, one cell per alias and boundary
  always_ff @(posedge clk_i) begin
    if (req_i.store_we) begin
      store_mem[{req_i.wr_alias, req_i.wr_bnd}] <= req_i.store_wdata;
    end
    if (req_i.rd_en) begin
      store_q <= store_mem[{req_i.rd_alias, req_i.rd_bnd}];
    end
  end

  // row memory for write marks and cell valid bits
  always_ff @(posedge clk_i) begin
    if (req_i.meta_we) begin
      meta_mem[req_i.wr_alias] <= req_i.meta_wdata;
    end
    if (req_i.rd_en) begin
      meta_q <= meta_mem[req_i.rd_alias];
    end
  end

  // a row that was never written since reset or clear reads as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rowv_q    <= '0;
      rd_rowv_q <= 1'b0;
    end else begin
      if (req_i.clear_all) begin
        rowv_q <= '0;
      end else if (req_i.meta_we) begin
        rowv_q[req_i.wr_alias] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_rowv_q <= rowv_q[req_i.rd_alias];
      end
    end
  end

  assign meta_rdata_o  = rd_rowv_q ? meta_q : '0;
  assign store_rdata_o = store_q;

endmodule

### rtl/aft_seq.sv
// command sequencer with shared compare/shift unit and result register
module aft_seq
  import aft_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [ALIAS_W-1:0]  alias_req_i,
  input  logic [TASK_W-1:0]   task_req_i,
  input  logic [BND_W-1:0]    boundary_i,
  input  logic [ACOUNT_W-1:0] alias_count_i,
  input  logic [TASK_W-1:0]   ntask_i,
  output mem_req_t            mem_req_o,
  input  meta_t               meta_rdata_i,
  input  logic [TASK_W-1:0]   store_rdata_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output res_t                res_o
);

  state_e state_q, state_d;

  logic [CMD_W-1:0]   cmd_q;
  logic [ALIAS_W-1:0] alias_q;
  logic [TASK_W-1:0]  task_q;
  logic [BND_W-1:0]   qb_q;

  logic [NUM_BND-1:0] rem_q, rem_d;
  logic [BND_W-1:0]   bnd_q, bnd_d;
  logic [POS_W-1:0]   cursor_q, cursor_d;
  logic               out_valid_q, out_valid_d;
  res_t               res_q, res_d;

  logic               accept;
  logic               out_free;
  logic               is_access;
  logic               cmd_known;
  logic [ACOUNT_W-1:0] alias_lim;
  logic               alias_ok;
  logic               task_bad;
  logic               qb_bad;
  logic               exec_err;
  logic [BND_W-1:0]   land;
  logic [BND_W-1:0]   task_p1;
  logic               upd;
  logic [NUM_BND-1:0] bnd_mask;
  logic [NUM_BND-1:0] marks;
  logic [POS_W-1:0]   cur_eff;
  logic               list_walk;
  logic               rem_last;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // command decode and range checks on the held beat
  assign is_access = (cmd_q == CMD_READ) || (cmd_q == CMD_MUTATE) || (cmd_q == CMD_OUTPUT);
  assign cmd_known = is_access || (cmd_q == CMD_LIST) || (cmd_q == CMD_QUERY)
                     || (cmd_q == CMD_CLEAR);
  assign alias_lim = (alias_count_i > ACOUNT_W'(MAX_ALIASES)) ? ACOUNT_W'(MAX_ALIASES)
                                                               : alias_count_i;
  assign alias_ok  = ACOUNT_W'(alias_q) < alias_lim;
  assign task_bad  = task_q >= ntask_i;
  assign qb_bad    = qb_q > ntask_i;
  assign exec_err  = !cmd_known || !alias_ok || (is_access && task_bad)
                     || ((cmd_q == CMD_QUERY) && qb_bad);

  // shared compare unit: landing cell and earliest-task update
  assign task_p1 = task_q + BND_W'(1);
  assign land    = (cmd_q == CMD_OUTPUT) ? task_p1 : task_q;
  assign upd     = !meta_rdata_i.cvalid[land] || (task_q < store_rdata_i);

  // boundaries in use are 0 .. ntask
  assign bnd_mask = {NUM_BND{1'b1}} >> (BND_W'(NUM_BND - 1) - ntask_i);
  assign marks    = meta_rdata_i.wmap & bnd_mask;
  assign cur_eff  = (alias_q == '0) ? '0 : cursor_q;
  assign list_walk = !exec_err && (cmd_q == CMD_LIST) && (marks != '0);
  assign rem_last  = (rem_q >> 1) == '0;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (list_walk) begin
          state_d = ST_LIST;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_LIST: begin
        if (rem_q[0] && out_free && rem_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // store requests, result beats and walk registers
  always_comb begin
    mem_req_o          = '0;
    mem_req_o.rd_en    = accept;
    mem_req_o.rd_alias = alias_req_i;
    mem_req_o.rd_bnd   = (cmd_i == CMD_OUTPUT) ? task_req_i + BND_W'(1) :
                         (cmd_i == CMD_QUERY)  ? boundary_i : task_req_i;
    mem_req_o.wr_alias = alias_q;
    mem_req_o.wr_bnd   = land;
    mem_req_o.store_wdata = task_q;
    mem_req_o.meta_wdata.cvalid = meta_rdata_i.cvalid | (NUM_BND'(1) << land);
    mem_req_o.meta_wdata.wmap   = meta_rdata_i.wmap |
      ((cmd_q != CMD_READ) ? (NUM_BND'(1) << task_p1) : '0);

    rem_d       = rem_q;
    bnd_d       = bnd_q;
    cursor_d    = cursor_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_d       = res_q;

    unique case (state_q)
      ST_IDLE: begin
      end
      ST_EXEC: begin
        if (list_walk) begin
          // start the boundary walk, no beat yet
          cursor_d = cur_eff;
          rem_d    = marks;
          bnd_d    = '0;
        end else if (out_free) begin
          out_valid_d     = 1'b1;
          res_d           = '0;
          res_d.last      = 1'b1;
          res_d.alias_out = alias_q;
          priority if (cmd_q == CMD_CLEAR) begin
            mem_req_o.clear_all = 1'b1;
            cursor_d        = '0;
            res_d.kind      = KIND_ACK;
            res_d.alias_out = '0;
          end else if (exec_err) begin
            res_d.kind = KIND_ERROR;
          end else if (is_access) begin
            mem_req_o.store_we = upd;
            mem_req_o.meta_we  = 1'b1;
            res_d.kind = KIND_ACK;
            res_d.bnd  = land;
          end else if (cmd_q == CMD_QUERY) begin
            res_d.kind  = KIND_ANSWER;
            res_d.bnd   = qb_q;
            res_d.found = meta_rdata_i.cvalid[qb_q];
            res_d.early = meta_rdata_i.cvalid[qb_q] ? store_rdata_i : '0;
          end else begin
            // list with no marks in range
            cursor_d   = cur_eff;
            res_d.kind = KIND_NONE;
            res_d.pos  = cur_eff;
          end
        end
      end
      ST_LIST: begin
        if (!rem_q[0] || out_free) begin
          rem_d = rem_q >> 1;
          bnd_d = bnd_q + BND_W'(1);
          if (rem_q[0]) begin
            out_valid_d     = 1'b1;
            res_d           = '0;
            res_d.kind      = KIND_ENTRY;
            res_d.alias_out = alias_q;
            res_d.bnd       = bnd_q;
            res_d.pos       = cursor_q;
            res_d.last      = rem_last;
            cursor_d        = cursor_q + POS_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rem_q       <= '0;
      bnd_q       <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      bnd_q       <= bnd_d;
      cursor_q    <= cursor_d;
      out_valid_q <= out_valid_d;
    end
  end

  // held input beat and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      alias_q <= alias_req_i;
      task_q  <= task_req_i;
      qb_q    <= boundary_i;
    end
    res_q <= res_d;
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

### rtl/access_fact_table_builder_top.sv
// top level of the access fact table builder: config registers, sequencer and stores
//
//  channel  dir  handshake              beat fields
//  in       in   in_valid_i/in_stall_o   cmd_i alias_req_i task_req_i boundary_i
//  out      out  out_valid_o/out_stall_i kind_o alias_out_o boundary_out_o position_o
//                                        earliest_task_o earliest_found_o last_o
//  cfg      in   cfg_we_i                cfg_idx_i cfg_data_i
//
//  access, query, clear and error beats: one memory read then one update
//  list: one read, then one boundary per cycle to the last marked one (task count+1 max)
//  the next input beat is taken once the final result sits in the output register
//  reset clears all row valid flops at once, no clearing pass is needed
//  a stalled output holds the sequencer; input stall stays high while busy
module access_fact_table_builder_top
  import aft_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CMD_W-1:0]      cmd_i,
  input  logic [ALIAS_W-1:0]    alias_req_i,
  input  logic [TASK_W-1:0]     task_req_i,
  input  logic [BND_W-1:0]      boundary_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [KIND_W-1:0]     kind_o,
  output logic [ALIAS_W-1:0]    alias_out_o,
  output logic [BND_W-1:0]      boundary_out_o,
  output logic [POS_W-1:0]      position_o,
  output logic [TASK_W-1:0]     earliest_task_o,
  output logic                  earliest_found_o,
  output logic                  last_o
);

  logic [ACOUNT_W-1:0] alias_count_q, alias_count_d;
  logic [TASK_W-1:0]   ntask_q, ntask_d;
  mem_req_t            mem_req;
  meta_t               meta_rdata;
  logic [TASK_W-1:0]   store_rdata;
  res_t                res;

  // configuration register writes
  always_comb begin
    alias_count_d = alias_count_q;
    ntask_d       = ntask_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ALIAS_COUNT: alias_count_d = cfg_data_i[ACOUNT_W-1:0];
        CFG_TASK_COUNT:  ntask_d       = cfg_data_i[TASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alias_count_q <= '0;
      ntask_q       <= '0;
    end else begin
      alias_count_q <= alias_count_d;
      ntask_q       <= ntask_d;
    end
  end

  aft_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .alias_req_i   (alias_req_i),
    .task_req_i    (task_req_i),
    .boundary_i    (boundary_i),
    .alias_count_i (alias_count_q),
    .ntask_i       (ntask_q),
    .mem_req_o     (mem_req),
    .meta_rdata_i  (meta_rdata),
    .store_rdata_i (store_rdata),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .res_o         (res)
  );

  aft_store u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (mem_req),
    .meta_rdata_o  (meta_rdata),
    .store_rdata_o (store_rdata)
  );

  // result beat onto the output ports
  assign kind_o           = res.kind;
  assign alias_out_o      = res.alias_out;
  assign boundary_out_o   = res.bnd;
  assign position_o       = res.pos;
  assign earliest_task_o  = res.early;
  assign earliest_found_o = res.found;
  assign last_o           = res.last;

endmodule

### rtl/aft_checker.sv
// port-level checker for the access fact table builder, bound to the top level
`include "access_fact_table_builder_top_macros.svh"

module aft_checker
  import aft_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [KIND_W-1:0]     kind_o,
  input logic [ALIAS_W-1:0]    alias_out_o,
  input logic [BND_W-1:0]      boundary_out_o,
  input logic [POS_W-1:0]      position_o,
  input logic [TASK_W-1:0]     earliest_task_o,
  input logic                  earliest_found_o,
  input logic                  last_o
);

  logic [KIND_W+ALIAS_W+BND_W+POS_W+TASK_W+1:0] beat_bits;

  // whole result payload as one vector
  assign beat_bits = {kind_o, alias_out_o, boundary_out_o, position_o, earliest_task_o,
                      earliest_found_o, last_o};

  // a stalled result beat holds
  `AFT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(beat_bits), "stalled beat changed")

  // the block is busy right after taking a beat
  `AFT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "input taken twice in a row")

  // only list entries can be followed by more results of the same command
  `AFT_ASSERT_NOW(a_single_last, out_valid_o && (kind_o != KIND_ENTRY), last_o, "single result without last")

  // no earliest task without a hit
  `AFT_ASSERT_NOW(a_found_task, out_valid_o && !earliest_found_o, earliest_task_o == '0, "earliest task set without hit")

endmodule

bind access_fact_table_builder_top aft_checker u_aft_checker (.*);
